### rtl/idpp_pkg.sv
// ----------------------------------------------------------------------------
// idpp_pkg
// Shared types and constants of the impact detector with pre-impact peaks.
// ----------------------------------------------------------------------------
package idpp_pkg;

  localparam int WINDOW_DEPTH = 20;
  localparam int PTR_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int SQRT_STEPS   = 16;
  localparam int MUL_STEPS    = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CRASH_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT_MS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_MS      = 2'd2;

  // reset values of the configuration registers
  localparam logic [15:0] RST_CRASH_THRESHOLD = 16'd5120;
  localparam logic [15:0] RST_HEARTBEAT_MS    = 16'd200;
  localparam logic [15:0] RST_HOLDOFF_MS      = 16'd3150;

  // result kinds
  localparam logic KIND_HEARTBEAT = 1'b0;
  localparam logic KIND_CRASH     = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic             capture;       // load a new sample, clear working registers
    logic             clear_holdoff; // sample survives the holdoff check
    logic             mul_en;        // square one axis and accumulate
    logic [2:0]       mul_sel;       // axis: ax, ay, az, rx, ry, rz
    logic             sqrt_step;     // one result bit of both square roots
    logic             rd_en;         // read one window slot
    logic [PTR_W-1:0] rd_addr;
    logic             peak_en;       // compare the slot read last cycle
    logic             commit;        // push sample, update timers, latch decisions
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             discard;       // sample falls inside the holdoff time
    logic [CNT_W-1:0] count;         // window slots holding samples
    logic             hb;            // heartbeat due for this sample
    logic             crash;         // crash seen on this sample
  } dp_status_t;

endpackage

### rtl/idpp_ram.sv
// ----------------------------------------------------------------------------
// idpp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module idpp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 20
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/idpp_datapath.sv
// ----------------------------------------------------------------------------
// idpp_datapath
// Sample registers, squaring unit, two bit-serial square roots, window RAM,
// peak tracking, timers and configuration registers.
// ----------------------------------------------------------------------------
module idpp_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [idpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [idpp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [31:0]                    time_ms,
  input  logic signed [15:0]             accel_x,
  input  logic signed [15:0]             accel_y,
  input  logic signed [15:0]             accel_z,
  input  logic signed [15:0]             rot_x,
  input  logic signed [15:0]             rot_y,
  input  logic signed [15:0]             rot_z,
  input  logic signed [15:0]             temperature,
  input  idpp_pkg::ctrl_cmd_t            cmd,
  output idpp_pkg::dp_status_t           status,
  output logic [15:0]                    impact_mag,
  output logic [15:0]                    rot_mag,
  output logic signed [15:0]             peak_accel_y,
  output logic signed [15:0]             peak_rot_z,
  output logic signed [15:0]             temp_out
);

  import idpp_pkg::*;

  function automatic logic [16:0] mag16(input logic [15:0] v);
    logic [16:0] sx;
    sx = {v[15], v};
    mag16 = sx[16] ? 17'(-sx) : sx;
  endfunction

  // one restoring step: {remainder, root}
  function automatic logic [35:0] sqrt_iter(input logic [19:0] rem, input logic [15:0] root,
                                            input logic [1:0] pair);
    logic [19:0] rs;
    logic [19:0] trial;
    rs    = {rem[17:0], pair};
    trial = {2'b00, root, 2'b01};
    if (rs >= trial) begin
      sqrt_iter = {20'(rs - trial), root[14:0], 1'b1};
    end else begin
      sqrt_iter = {rs, root[14:0], 1'b0};
    end
  endfunction

  // configuration
  logic [15:0] crash_threshold;
  logic [15:0] heartbeat_ms;
  logic [15:0] holdoff_ms;

  // sample
  logic [31:0] t;
  logic [15:0] ax, ay, az, rx, ry, rz;

  // magnitudes
  logic [31:0] acc_a, acc_r;
  logic [19:0] rem_a, rem_r;
  logic [15:0] root_a, root_r;

  // window and timers
  logic [PTR_W-1:0] write_pos;
  logic             window_full;
  logic [31:0]      last_hb_time;
  logic [31:0]      holdoff_start;
  logic             holdoff_active;
  logic             hb_flag, crash_flag;

  logic [31:0]      ram_rdata;
  logic [15:0]      peak_ay, peak_rz;

  logic [15:0]      mul_op;
  logic [16:0]      mul_mag;
  logic [33:0]      mul_prod;
  logic [35:0]      sq_a_next, sq_r_next;
  logic [31:0]      hold_elapsed, hb_elapsed;
  logic             hb_due, crash_due;

  always_ff @(posedge clk) begin
    if (rst) begin
      crash_threshold <= RST_CRASH_THRESHOLD;
      heartbeat_ms    <= RST_HEARTBEAT_MS;
      holdoff_ms      <= RST_HOLDOFF_MS;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CRASH_THRESHOLD: crash_threshold <= cfg_data;
        REG_HEARTBEAT_MS:    heartbeat_ms    <= cfg_data;
        REG_HOLDOFF_MS:      holdoff_ms      <= cfg_data;
        default: ;
      endcase
    end
  end

  // squaring unit: one axis per cycle
  always_comb begin
    unique case (cmd.mul_sel)
      3'd0:    mul_op = ax;
      3'd1:    mul_op = ay;
      3'd2:    mul_op = az;
      3'd3:    mul_op = rx;
      3'd4:    mul_op = ry;
      default: mul_op = rz;
    endcase
    mul_mag  = mag16(mul_op);
    mul_prod = mul_mag * mul_mag;
  end

  assign sq_a_next = sqrt_iter(rem_a, root_a, acc_a[31:30]);
  assign sq_r_next = sqrt_iter(rem_r, root_r, acc_r[31:30]);

  assign hold_elapsed = t - holdoff_start;
  assign hb_elapsed   = t - last_hb_time;
  assign hb_due       = hb_elapsed > {16'd0, heartbeat_ms};
  assign crash_due    = root_a > crash_threshold;

  // sample, accumulators, roots and peaks: payload, no reset
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      t       <= time_ms;
      ax      <= accel_x;
      ay      <= accel_y;
      az      <= accel_z;
      rx      <= rot_x;
      ry      <= rot_y;
      rz      <= rot_z;
      temp_out <= temperature;
      acc_a   <= '0;
      acc_r   <= '0;
      rem_a   <= '0;
      rem_r   <= '0;
      root_a  <= '0;
      root_r  <= '0;
      peak_ay <= '0;
      peak_rz <= '0;
    end else begin
      if (cmd.mul_en) begin
        if (cmd.mul_sel < 3'd3) begin
          acc_a <= acc_a + 32'(mul_prod);
        end else begin
          acc_r <= acc_r + 32'(mul_prod);
        end
      end
      if (cmd.sqrt_step) begin
        acc_a  <= {acc_a[29:0], 2'b00};
        acc_r  <= {acc_r[29:0], 2'b00};
        rem_a  <= sq_a_next[35:16];
        root_a <= sq_a_next[15:0];
        rem_r  <= sq_r_next[35:16];
        root_r <= sq_r_next[15:0];
      end
      if (cmd.peak_en) begin
        if (mag16(ram_rdata[31:16]) > mag16(peak_ay)) begin
          peak_ay <= ram_rdata[31:16];
        end
        if (mag16(ram_rdata[15:0]) > mag16(peak_rz)) begin
          peak_rz <= ram_rdata[15:0];
        end
      end
    end
  end

  // window position, timers and decisions
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos      <= '0;
      window_full    <= 1'b0;
      last_hb_time   <= '0;
      holdoff_start  <= '0;
      holdoff_active <= 1'b0;
      hb_flag        <= 1'b0;
      crash_flag     <= 1'b0;
    end else begin
      if (cmd.clear_holdoff) begin
        holdoff_active <= 1'b0;
      end
      if (cmd.commit) begin
        if (write_pos == PTR_W'(WINDOW_DEPTH - 1)) begin
          write_pos   <= '0;
          window_full <= 1'b1;
        end else begin
          write_pos <= write_pos + 1'b1;
        end
        hb_flag    <= hb_due;
        crash_flag <= crash_due;
        if (hb_due) begin
          last_hb_time <= t;
        end
        if (crash_due) begin
          holdoff_active <= 1'b1;
          holdoff_start  <= t;
        end
      end
    end
  end

  idpp_ram #(
    .WIDTH (32),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (write_pos),
    .wdata ({ay, rz}),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_addr),
    .rdata (ram_rdata)
  );

  assign status.discard = holdoff_active && (hold_elapsed < {16'd0, holdoff_ms});
  assign status.count   = window_full ? CNT_W'(WINDOW_DEPTH) : CNT_W'(write_pos);
  assign status.hb      = hb_flag;
  assign status.crash   = crash_flag;

  assign impact_mag   = root_a;
  assign rot_mag      = root_r;
  assign peak_accel_y = peak_ay;
  assign peak_rot_z   = peak_rz;

endmodule

### rtl/idpp_ctrl.sv
// ----------------------------------------------------------------------------
// idpp_ctrl
// Sequencer: accept, holdoff check, squaring, square roots, window scan,
// commit and result delivery.
// ----------------------------------------------------------------------------
module idpp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic                  kind,
  output logic                  last,
  output idpp_pkg::ctrl_cmd_t   cmd,
  input  idpp_pkg::dp_status_t  status
);

  import idpp_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_SQRT,
    S_SCAN,
    S_COMMIT,
    S_DECIDE,
    S_HB,
    S_CRASH
  } state_t;

  state_t           state;
  logic [3:0]       step;
  logic [CNT_W-1:0] scan_addr;
  logic             scan_pend;
  logic             scan_more;

  assign scan_more = scan_addr < status.count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      scan_addr <= '0;
      scan_pend <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (sample_valid) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          step  <= '0;
          state <= status.discard ? S_IDLE : S_MUL;
        end
        S_MUL: begin
          if (step == 4'(MUL_STEPS - 1)) begin
            step  <= '0;
            state <= S_SQRT;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_SQRT: begin
          if (step == 4'(SQRT_STEPS - 1)) begin
            step      <= '0;
            scan_addr <= '0;
            scan_pend <= 1'b0;
            state     <= S_SCAN;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_SCAN: begin
          scan_pend <= scan_more;
          if (scan_more) begin
            scan_addr <= scan_addr + 1'b1;
          end else if (!scan_pend) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          priority if (status.hb) begin
            state <= S_HB;
          end else if (status.crash) begin
            state <= S_CRASH;
          end else begin
            state <= S_IDLE;
          end
        end
        S_HB: begin
          if (!result_stall) begin
            state <= status.crash ? S_CRASH : S_IDLE;
          end
        end
        S_CRASH: begin
          if (!result_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd               = '0;
    cmd.capture       = (state == S_IDLE) && sample_valid;
    cmd.clear_holdoff = (state == S_CHECK) && !status.discard;
    cmd.mul_en        = (state == S_MUL);
    cmd.mul_sel       = step[2:0];
    cmd.sqrt_step     = (state == S_SQRT);
    cmd.rd_en         = (state == S_SCAN) && scan_more;
    cmd.rd_addr       = scan_addr[PTR_W-1:0];
    cmd.peak_en       = (state == S_SCAN) && scan_pend;
    cmd.commit        = (state == S_COMMIT);
  end

  assign sample_stall = (state != S_IDLE);
  assign result_valid = (state == S_HB) || (state == S_CRASH);
  assign kind         = (state == S_CRASH) ? KIND_CRASH : KIND_HEARTBEAT;
  assign last         = (state == S_CRASH) || !status.crash;

endmodule

### rtl/impact_detector_with_preimpact_peaks.sv
// ----------------------------------------------------------------------------
// impact_detector_with_preimpact_peaks
// Crash and heartbeat detector over timestamped inertial samples.
// ----------------------------------------------------------------------------
// One item at a time. After a sample is taken the block checks the holdoff
// time, squares the six axes on one shared multiplier, forms both floor
// square roots bit by bit in parallel, scans the window RAM through its
// single read port over the stored samples only, commits and decides, then
// presents each result until it is taken. A sample discarded by the holdoff
// goes straight back to idle. sample_stall is high from the cycle after
// acceptance until the block is back in idle. When a sample gives both a
// heartbeat and a crash, the heartbeat comes out first and only the crash
// carries last. The window RAM holds Y acceleration and Z rotation of the
// latest samples; only slots already written are scanned, so it needs no
// clearing after reset.
// Write configuration registers only while idle.
// ----------------------------------------------------------------------------
module impact_detector_with_preimpact_peaks (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_write,
  input  logic [idpp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [idpp_pkg::CFG_DATA_W-1:0] cfg_data,
  // sample channel
  input  logic                            sample_valid,
  output logic                            sample_stall,
  input  logic [31:0]                     time_ms,
  input  logic signed [15:0]              accel_x,
  input  logic signed [15:0]              accel_y,
  input  logic signed [15:0]              accel_z,
  input  logic signed [15:0]              rot_x,
  input  logic signed [15:0]              rot_y,
  input  logic signed [15:0]              rot_z,
  input  logic signed [15:0]              temperature,
  // result channel
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic                            kind,
  output logic [15:0]                     impact_mag,
  output logic [15:0]                     rot_mag,
  output logic signed [15:0]              peak_accel_y,
  output logic signed [15:0]              peak_rot_z,
  output logic signed [15:0]              temp_out,
  output logic                            last
);

  import idpp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // sequencer: handshakes, step counters, window scan addressing
  idpp_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .last         (last),
    .cmd          (cmd),
    .status       (status)
  );

  // datapath: result fields hold steady while a result waits
  idpp_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .time_ms      (time_ms),
    .accel_x      (accel_x),
    .accel_y      (accel_y),
    .accel_z      (accel_z),
    .rot_x        (rot_x),
    .rot_y        (rot_y),
    .rot_z        (rot_z),
    .temperature  (temperature),
    .cmd          (cmd),
    .status       (status),
    .impact_mag   (impact_mag),
    .rot_mag      (rot_mag),
    .peak_accel_y (peak_accel_y),
    .peak_rot_z   (peak_rot_z),
    .temp_out     (temp_out)
  );

endmodule
